FILE: rtl/khst_pkg.sv
// Shared types and constants for the keypad scan and hold timer unit.
// Used by the top level and by the remainder unit; depends on nothing.
package khst_pkg;

    localparam int NUM_KEYS = 16;
    localparam int KEY_IDX_W = 4;
    localparam int KEY_CODE_W = 5;
    localparam int COL_W = 2;
    localparam int ROWS = 4;
    localparam int PERIOD_W = 8;
    localparam int LONG_W = 16;
    localparam int DIV_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W = 2;

    // Command codes
    localparam logic [1:0] CMD_SCAN     = 2'd0;
    localparam logic [1:0] CMD_CLR_KEYS = 2'd1;
    localparam logic [1:0] CMD_CLR_HOLD = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_DIVIDER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_COUNT = 2'd2;

    // Register reset values
    localparam logic [DIV_W-1:0]    UPDATE_DIVIDER_RST   = 4'd4;
    localparam logic [PERIOD_W-1:0] REPEAT_PERIOD_RST    = 8'd12;
    localparam logic [LONG_W-1:0]   LONG_PRESS_COUNT_RST = 16'd75;

    // Status of the remainder unit
    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

    // Key bit wired to a column and row
    function automatic logic [KEY_IDX_W-1:0] col_row_key(
        input logic [COL_W-1:0] col,
        input logic [1:0]       row
    );
        logic [KEY_IDX_W-1:0] k;
        begin
            k = '0;
            case ({col, row})
                4'h0: k = 4'd0;
                4'h1: k = 4'd3;
                4'h2: k = 4'd6;
                4'h3: k = 4'd14;
                4'h4: k = 4'd1;
                4'h5: k = 4'd4;
                4'h6: k = 4'd7;
                4'h7: k = 4'd9;
                4'h8: k = 4'd2;
                4'h9: k = 4'd5;
                4'hA: k = 4'd8;
                4'hB: k = 4'd15;
                4'hC: k = 4'd10;
                4'hD: k = 4'd11;
                4'hE: k = 4'd12;
                4'hF: k = 4'd13;
                default: k = '0;
            endcase
            return k;
        end
    endfunction

endpackage

FILE: rtl/keypad_scan_hold_timer_unit.sv
// 4x4 keypad scanner with per-key hold timers: top level and sequencer.
// Depends on khst_pkg and the remainder unit khst_rem.
//
// Each input word is one command (s_tuser): a scan tick carrying the row levels
// of the driven column, a clear of the key states, or a clear of the hold
// counters and the long press flag. Every input word yields exactly one output
// word with the next drive column, the key states and any hold events. The
// block takes one word at a time. A scan tick that updates the hold counters
// walks the 16 counters with a single incrementer, one per cycle; when the
// event key's count needs the repeat check, a bit-serial remainder unit then
// works through the count at one bit per cycle. Output words sit in a register
// until taken; a finished word waits there if m_tready is low.
module keypad_scan_hold_timer_unit #(
    parameter int HOLD_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [khst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [khst_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [3:0] row_levels
    input  logic [1:0]                      s_tuser,  // [1:0] cmd
    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] column_drive, [17:2] key_states, [22:18] event_key,
    // [23] repeat_event, [24] long_event, [25] long_flag
    output logic [31:0]                     m_tdata
);
    import khst_pkg::*;

    localparam int CMP_W = (HOLD_WIDTH > LONG_W) ? HOLD_WIDTH : LONG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HOLD,
        S_CHECK,
        S_REM,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [DIV_W-1:0]      update_divider_reg;
    logic [PERIOD_W-1:0]   repeat_period_reg;
    logic [LONG_W-1:0]     long_press_count_reg;
    logic [COL_W-1:0]      drive_column_reg;
    logic [DIV_W-1:0]      tick_divider_reg;
    logic [NUM_KEYS-1:0]   key_bits_reg;
    logic [HOLD_WIDTH-1:0] hold_reg [NUM_KEYS];
    logic                  long_seen_reg;
    logic [KEY_IDX_W-1:0]  key_idx_reg;
    logic [KEY_CODE_W-1:0] ev_key_reg;
    logic [HOLD_WIDTH-1:0] time_reg;
    logic                  rep_reg;
    logic                  lng_reg;
    logic                  m_tvalid_reg;
    logic [31:0]           m_tdata_reg;

    logic                  in_acc;
    logic [NUM_KEYS-1:0]   scan_bits;
    logic [HOLD_WIDTH-1:0] hold_inc;
    logic                  rem_start;
    logic                  ev_live;
    rem_status_t           rem_status;

    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Key states after scanning the driven column: first high row wins
    always_comb
    begin
        logic found;
        found     = 1'b0;
        scan_bits = key_bits_reg;
        for (int r = 0; r < ROWS; r++)
        begin
            scan_bits[col_row_key(drive_column_reg, 2'(r))] = 1'b0;
            if (!found && s_tdata[r])
            begin
                scan_bits[col_row_key(drive_column_reg, 2'(r))] = 1'b1;
                found = 1'b1;
            end
        end
    end

    // Shared incrementer for the hold counter walk
    assign hold_inc  = hold_reg[key_idx_reg] + 1'b1;
    assign ev_live   = (ev_key_reg != '0) && (time_reg != '0);
    assign rem_start = (state_reg == S_CHECK) && ev_live && (repeat_period_reg != '0);

    khst_rem #(
        .HOLD_WIDTH (HOLD_WIDTH)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (time_reg),
        .divisor  (repeat_period_reg),
        .status   (rem_status)
    );

    // Sequencer, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            update_divider_reg   <= UPDATE_DIVIDER_RST;
            repeat_period_reg    <= REPEAT_PERIOD_RST;
            long_press_count_reg <= LONG_PRESS_COUNT_RST;
            drive_column_reg     <= '0;
            tick_divider_reg     <= DIV_W'(1);
            key_bits_reg         <= '0;
            for (int k = 0; k < NUM_KEYS; k++)
                hold_reg[k] <= '0;
            long_seen_reg        <= 1'b0;
            key_idx_reg          <= '0;
            ev_key_reg           <= '0;
            time_reg             <= '0;
            rep_reg              <= 1'b0;
            lng_reg              <= 1'b0;
            m_tvalid_reg         <= 1'b0;
            m_tdata_reg          <= '0;
        end
        else
        begin
            // Write configuration
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_UPDATE_DIVIDER:   update_divider_reg   <= cfg_data[DIV_W-1:0];
                    REG_REPEAT_PERIOD:    repeat_period_reg    <= cfg_data[PERIOD_W-1:0];
                    REG_LONG_PRESS_COUNT: long_press_count_reg <= cfg_data[LONG_W-1:0];
                    default: ;
                endcase
            end

            // Drop the output word once taken, unless a new one loads
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE))
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        ev_key_reg  <= '0;
                        time_reg    <= '0;
                        rep_reg     <= 1'b0;
                        lng_reg     <= 1'b0;
                        key_idx_reg <= '0;
                        state_reg   <= S_DONE;
                        case (s_tuser)
                            CMD_SCAN:
                            begin
                                key_bits_reg     <= scan_bits;
                                drive_column_reg <= drive_column_reg + 1'b1;
                                if (tick_divider_reg == update_divider_reg)
                                begin
                                    tick_divider_reg <= DIV_W'(1);
                                    state_reg        <= S_HOLD;
                                end
                                else
                                begin
                                    tick_divider_reg <= tick_divider_reg + 1'b1;
                                end
                            end
                            CMD_CLR_KEYS:
                            begin
                                key_bits_reg <= '0;
                            end
                            CMD_CLR_HOLD:
                            begin
                                for (int k = 0; k < NUM_KEYS; k++)
                                    hold_reg[k] <= '0;
                                long_seen_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end

                // Advance one hold counter per cycle; remember the last held key
                S_HOLD:
                begin
                    if (key_bits_reg[key_idx_reg])
                    begin
                        hold_reg[key_idx_reg] <= hold_inc;
                        ev_key_reg            <= KEY_CODE_W'(key_idx_reg) + 1'b1;
                        time_reg              <= hold_inc;
                    end
                    else
                    begin
                        hold_reg[key_idx_reg] <= '0;
                    end
                    key_idx_reg <= key_idx_reg + 1'b1;
                    if (key_idx_reg == KEY_IDX_W'(NUM_KEYS - 1))
                        state_reg <= S_CHECK;
                end

                // Long press compare; launch the repeat check if it applies
                S_CHECK:
                begin
                    if (ev_live && (CMP_W'(time_reg) == CMP_W'(long_press_count_reg)))
                    begin
                        lng_reg       <= 1'b1;
                        long_seen_reg <= 1'b1;
                    end
                    state_reg <= rem_start ? S_REM : S_DONE;
                end

                S_REM:
                begin
                    if (rem_status.done)
                    begin
                        rep_reg   <= rem_status.zero;
                        state_reg <= S_DONE;
                    end
                end

                // Load the output word when the register is free
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'b0, long_seen_reg, lng_reg, rep_reg,
                                         ev_key_reg, key_bits_reg, drive_column_reg};
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/khst_rem.sv
// Bit-serial remainder unit: hold count modulo repeat period, one bit a cycle.
// Depends on khst_pkg for the period width and the status struct.
module khst_rem #(
    parameter int HOLD_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [HOLD_WIDTH-1:0]        dividend,
    input  logic [khst_pkg::PERIOD_W-1:0] divisor,
    output khst_pkg::rem_status_t        status
);
    import khst_pkg::*;

    localparam int CNT_W = $clog2(HOLD_WIDTH + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [HOLD_WIDTH-1:0] quo_reg;
    logic [PERIOD_W-1:0]   rem_reg;
    logic [PERIOD_W:0]     trial;
    logic [PERIOD_W:0]     diff;

    // Bring down the next dividend bit and try the subtraction
    assign trial = {rem_reg, quo_reg[HOLD_WIDTH-1]};
    assign diff  = trial - {1'b0, divisor};

    // Restoring remainder sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(HOLD_WIDTH);
                quo_reg  <= dividend;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (trial >= {1'b0, divisor})
                    rem_reg <= diff[PERIOD_W-1:0];
                else
                    rem_reg <= trial[PERIOD_W-1:0];
                quo_reg <= {quo_reg[HOLD_WIDTH-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule

FILE: rtl/khst_checker.sv
// Port-level checks for keypad_scan_hold_timer_unit, bound to the top level.
// Depends only on the top level's ports.
module khst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // Event code never exceeds the key count
    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[22:18] <= 5'd16))
        else $error("event_key out of range");

    // Repeat or long events come only with an event key
    a_event_key: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[23] || m_tdata[24])) |-> (m_tdata[22:18] != 5'd0))
        else $error("event without event key");

    // A long press event shows the sticky flag set
    a_long_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[24]) |-> m_tdata[25])
        else $error("long event without flag");

    // One word at a time: ready drops after an accepted input word
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while busy");

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output word changed under stall");

endmodule

bind keypad_scan_hold_timer_unit khst_checker u_khst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: dv/keypad_scan_hold_timer_unit_test.sv
`timescale 1ns / 1ps
// Testbench for keypad_scan_hold_timer_unit: streams scan ticks and clear commands in,
// predicts every output word in the bench and checks it field by field.
// Depends on khst_pkg and the unit's RTL.
module keypad_scan_hold_timer_unit_test;
    import khst_pkg::*;

    localparam int HOLD_BITS = 16;
    localparam int CLK_HALF = 10;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 60;
    // Command code with no meaning: the unit leaves its state alone
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [COL_W-1:0]      column;
        logic [NUM_KEYS-1:0]   keys;
        logic [KEY_CODE_W-1:0] event_key;
        logic                  repeat_hit;
        logic                  long_hit;
        logic                  long_flag;
    } keypad_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [3:0] row_levels
    logic [1:0]            s_tuser;   // [1:0] cmd
    logic                  m_tvalid;
    logic                  m_tready;
    // [1:0] column_drive, [17:2] key_states, [22:18] event_key,
    // [23] repeat_event, [24] long_event, [25] long_flag
    logic [31:0]           m_tdata;

    keypad_word_t expected_words[$];
    keypad_word_t got_word;
    int           error_count = 0;
    int           idle_cycles = 0;
    bit           steady;

    // Predicted state of the scanner and its registers
    logic [COL_W-1:0]     pred_column;
    logic [DIV_W-1:0]     pred_tick;
    logic [NUM_KEYS-1:0]  pred_keys;
    logic [HOLD_BITS-1:0] pred_hold [NUM_KEYS];
    logic                 pred_long_seen;
    logic [DIV_W-1:0]     pred_divider;
    logic [PERIOD_W-1:0]  pred_period;
    logic [LONG_W-1:0]    pred_long_count;

    // Row levels that the pretend keypad shows on each column
    logic [ROWS-1:0]      held_rows [4];

    keypad_scan_hold_timer_unit #(
        .HOLD_WIDTH(HOLD_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Key bit wired to a column and a row
    function automatic logic [KEY_IDX_W-1:0] key_bit(input logic [COL_W-1:0] col,
                                                     input logic [1:0] row);
        if (col == 2'd3)
            return KEY_IDX_W'(10) + KEY_IDX_W'(row);
        if (row != 2'd3)
            return KEY_IDX_W'(row) * KEY_IDX_W'(3) + KEY_IDX_W'(col);
        return (col == 2'd0) ? KEY_IDX_W'(14) : (col == 2'd1) ? KEY_IDX_W'(9) : KEY_IDX_W'(15);
    endfunction

    function automatic void reset_predictor();
        pred_column = '0;
        pred_tick = 4'd1;
        pred_keys = '0;
        for (int k = 0; k < NUM_KEYS; k++)
            pred_hold[k] = '0;
        pred_long_seen = 1'b0;
        pred_divider = UPDATE_DIVIDER_RST;
        pred_period = REPEAT_PERIOD_RST;
        pred_long_count = LONG_PRESS_COUNT_RST;
    endfunction

    // Advance the predicted state by one accepted word and queue its output word
    function automatic void predict_keypad_word(input logic [1:0] cmd,
                                                input logic [ROWS-1:0] rows);
        keypad_word_t         w;
        bit                   found;
        logic [KEY_CODE_W-1:0] last;
        logic [HOLD_BITS-1:0] count;
        w = '0;
        found = 1'b0;
        last = '0;
        count = '0;
        case (cmd)
            CMD_SCAN:
            begin
                // lowest high row wins, the rest of the column drops
                for (int r = 0; r < ROWS; r++)
                begin
                    pred_keys[key_bit(pred_column, 2'(r))] = 1'b0;
                    if (!found && rows[r])
                    begin
                        pred_keys[key_bit(pred_column, 2'(r))] = 1'b1;
                        found = 1'b1;
                    end
                end
                pred_column = pred_column + 1'b1;
                if (pred_tick == pred_divider)
                begin
                    pred_tick = 4'd1;
                    for (int k = 0; k < NUM_KEYS; k++)
                    begin
                        if (pred_keys[k])
                        begin
                            pred_hold[k] = pred_hold[k] + 1'b1;
                            last = KEY_CODE_W'(k + 1);
                            count = pred_hold[k];
                        end
                        else
                            pred_hold[k] = '0;
                    end
                    w.event_key = last;
                    if (last != 0 && count != 0)
                    begin
                        if (pred_period != 0 && count % pred_period == 0)
                            w.repeat_hit = 1'b1;
                        if (count == pred_long_count)
                        begin
                            w.long_hit = 1'b1;
                            pred_long_seen = 1'b1;
                        end
                    end
                end
                else
                    pred_tick = pred_tick + 1'b1;
            end
            CMD_CLR_KEYS:
                pred_keys = '0;
            CMD_CLR_HOLD:
            begin
                for (int k = 0; k < NUM_KEYS; k++)
                    pred_hold[k] = '0;
                pred_long_seen = 1'b0;
            end
            default:
                ;
        endcase
        w.column = pred_column;
        w.keys = pred_keys;
        w.long_flag = pred_long_seen;
        expected_words.push_back(w);
    endfunction

    function automatic logic [ROWS-1:0] random_rows();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return '0;
        if (pick < 8)
            return ROWS'(1) << $urandom_range(ROWS - 1);
        return ROWS'($urandom_range(15));
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Write all three registers; the unit must be idle
    task automatic write_registers(input logic [DIV_W-1:0] divider,
                                   input logic [PERIOD_W-1:0] period,
                                   input logic [LONG_W-1:0] long_count);
        cfg_we <= 1'b1;
        cfg_index <= REG_UPDATE_DIVIDER;
        cfg_data <= CFG_DATA_W'(divider);
        @(posedge clk);
        cfg_index <= REG_REPEAT_PERIOD;
        cfg_data <= CFG_DATA_W'(period);
        @(posedge clk);
        cfg_index <= REG_LONG_PRESS_COUNT;
        cfg_data <= long_count;
        @(posedge clk);
        cfg_we <= 1'b0;
        pred_divider = divider;
        pred_period = period;
        pred_long_count = long_count;
    endtask

    // Send one word, with a random gap ahead of it unless idling is off
    task automatic send_keypad_word(input logic [1:0] cmd, input logic [ROWS-1:0] rows);
        if (!steady && $urandom_range(99) < 27)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 27);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {4'b0000, rows};
        do
            @(posedge clk);
        while (!s_tready);
        predict_keypad_word(cmd, rows);
    endtask

    task automatic send_held_ticks(input int count);
        repeat (count)
            send_keypad_word(CMD_SCAN, held_rows[pred_column]);
    endtask

    // Drop valid and hold until every expected word has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    // Row priority, every column, clears, an unused command, at reset settings
    task automatic test_scan_and_clears();
        send_keypad_word(CMD_NONE, 4'hF);
        send_keypad_word(CMD_SCAN, 4'hF);
        send_keypad_word(CMD_SCAN, 4'h8);
        send_keypad_word(CMD_SCAN, 4'h0);
        send_keypad_word(CMD_SCAN, 4'h6);
        send_keypad_word(CMD_CLR_KEYS, 4'hF);
        send_keypad_word(CMD_CLR_HOLD, 4'hA);
        send_keypad_word(CMD_SCAN, 4'h4);
        send_keypad_word(CMD_SCAN, 4'h2);
        send_keypad_word(CMD_SCAN, 4'h1);
        send_keypad_word(CMD_SCAN, 4'h8);
        send_keypad_word(CMD_SCAN, 4'hC);
        drain_results();
    endtask

    // Repeat and long press events on the last key, flag clear, period zero
    task automatic test_events_and_flag();
        write_registers(4'd1, 8'd2, 16'd3);
        held_rows[0] = '0;
        held_rows[1] = '0;
        held_rows[2] = 4'h8;
        held_rows[3] = '0;
        send_held_ticks(8);
        send_keypad_word(CMD_CLR_HOLD, 4'h0);
        drain_results();
        write_registers(4'd1, 8'd0, 16'd1);
        send_held_ticks(3);
        drain_results();
    endtask

    // Mostly a steady keypad with random presses, mixed with noise and clears
    task automatic test_random_phase(input logic [DIV_W-1:0] divider,
                                     input logic [PERIOD_W-1:0] period,
                                     input logic [LONG_W-1:0] long_count,
                                     input int items, input bit no_idle);
        int pick;
        write_registers(divider, period, long_count);
        steady = no_idle;
        for (int c = 0; c < 4; c++)
            held_rows[c] = random_rows();
        repeat (items)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                held_rows[2'($urandom_range(3))] = random_rows();
            if (pick < 80)
                send_keypad_word(CMD_SCAN, held_rows[pred_column]);
            else if (pick < 90)
                send_keypad_word(CMD_SCAN, ROWS'($urandom_range(15)));
            else if (pick < 95)
                send_keypad_word(CMD_CLR_KEYS, ROWS'($urandom_range(15)));
            else if (pick < 98)
                send_keypad_word(CMD_CLR_HOLD, ROWS'($urandom_range(15)));
            else
                send_keypad_word(CMD_NONE, ROWS'($urandom_range(15)));
        end
        drain_results();
        steady = 1'b0;
    endtask

    // Stall the output side at random
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= 27);

    // Compare each output word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("output word with none expected: m_tdata %h", m_tdata);
                error_count++;
            end
            else
            begin
                got_word = expected_words.pop_front();
                check_field("column_drive", 32'(got_word.column), 32'(m_tdata[1:0]));
                check_field("key_states", 32'(got_word.keys), 32'(m_tdata[17:2]));
                check_field("event_key", 32'(got_word.event_key), 32'(m_tdata[22:18]));
                check_field("repeat_event", 32'(got_word.repeat_hit), 32'(m_tdata[23]));
                check_field("long_event", 32'(got_word.long_hit), 32'(m_tdata[24]));
                check_field("long_flag", 32'(got_word.long_flag), 32'(m_tdata[25]));
            end
        end
    end

    // End the run once nothing has moved for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL keypad_scan_hold_timer_unit");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= CMD_SCAN;
        steady = 1'b0;
        reset_predictor();
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_scan_and_clears();
        test_events_and_flag();
        test_random_phase(4'd15, 8'd255, 16'd65535, 170, 1'b0);
        test_random_phase(4'd1, 8'd1, 16'd1, 170, 1'b0);
        test_random_phase(4'd0, 8'd0, 16'd20, 170, 1'b0);
        test_random_phase(4'd2, 8'd5, 16'd12, 170, 1'b1);
        test_random_phase(4'd3, 8'd4, 16'd25, 170, 1'b0);
        test_random_phase(UPDATE_DIVIDER_RST, REPEAT_PERIOD_RST, LONG_PRESS_COUNT_RST,
                          170, 1'b0);

        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("PASS keypad_scan_hold_timer_unit");
        else
            $display("FAIL keypad_scan_hold_timer_unit");
        $finish;
    end

endmodule
